>>> rtl/core/tppr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Turbine pitch regulator package
// Shared types, register codes and reset values of the pitch and power
// regulator.
// ----------------------------------------------------------------------------
package tppr_pkg;

   // Operating modes, encoded as reported in mode_now.
   typedef enum logic [2:0] {
      MODE_START  = 3'd0,
      MODE_NORMAL = 3'd1,
      MODE_REG    = 3'd2,
      MODE_STOP   = 3'd3,
      MODE_DISC   = 3'd4
   } mode_type;

   // Event report codes.
   localparam logic [1:0] REPORT_ONLINE  = 2'd0;
   localparam logic [1:0] REPORT_STOP    = 2'd1;
   localparam logic [1:0] REPORT_RELEASE = 2'd2;

   // Serial command that requests a load disconnect ('D').
   localparam logic [7:0] CMD_DISCONNECT = 8'd68;

   // Power error width and its saturation value.
   localparam int ERR_W = 20;
   localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_START_VOLTAGE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_POWER  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_BAND    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_STEP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_PITCH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUT_IN_PITCH  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PITCH     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PITCH     = 3'd7;

   // Register reset values.
   localparam logic [9:0]       RST_START_VOLTAGE = 10'd48;
   localparam logic [ERR_W-1:0] RST_TARGET_POWER  = 20'd13256;
   localparam logic [ERR_W-1:0] RST_POWER_BAND    = 20'd279;
   localparam logic [5:0]       RST_PITCH_STEP    = 6'd3;
   localparam logic [7:0]       RST_NORMAL_PITCH  = 8'd90;
   localparam logic [7:0]       RST_CUT_IN_PITCH  = 8'd50;
   localparam logic [7:0]       RST_MIN_PITCH     = 8'd50;
   localparam logic [7:0]       RST_MAX_PITCH     = 8'd140;

   // Reset value of the regulated pitch.
   localparam logic [7:0] RST_REGULATED_PITCH = 8'd90;

   // Configuration register contents.
   typedef struct packed {
      logic [9:0]       start_voltage_counts;
      logic [ERR_W-1:0] target_power;
      logic [ERR_W-1:0] power_band;
      logic [5:0]       pitch_step;
      logic [7:0]       normal_pitch;
      logic [7:0]       cut_in_pitch;
      logic [7:0]       min_pitch;
      logic [7:0]       max_pitch;
   } cfg_type;

endpackage
`default_nettype wire

>>> rtl/core/tppr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Carries one control tick word: ADC sample, stop level and command byte.
// ----------------------------------------------------------------------------
interface tppr_req_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] current_sample;
   logic                   stop_released;
   logic                   cmd_valid;
   logic [7:0]             cmd_byte;

   modport source (
      output valid, current_sample, stop_released, cmd_valid, cmd_byte,
      input  ready
   );
   modport sink (
      input  valid, current_sample, stop_released, cmd_valid, cmd_byte,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/core/tppr_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Carries one result word: pitch command, relay state, event report, mode.
// ----------------------------------------------------------------------------
interface tppr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pitch_command;
   logic       relay_open;
   logic       report_valid;
   logic [1:0] report_code;
   logic [2:0] mode_now;

   modport source (
      output valid, pitch_command, relay_open, report_valid, report_code, mode_now,
      input  ready
   );
   modport sink (
      input  valid, pitch_command, relay_open, report_valid, report_code, mode_now,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/core/tppr_csr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data word to write there.
// ----------------------------------------------------------------------------
interface tppr_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tppr_pkg::CSR_INDEX_W-1:0] index;
   logic [tppr_pkg::CSR_DATA_W-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/core/tppr_csr_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Regulator configuration registers
// Takes writes from the configuration channel and holds the eight control
// registers, each truncated to its own width.
// ----------------------------------------------------------------------------
module tppr_csr_regs (
   input  wire logic        clock,
   input  wire logic        reset,
   tppr_csr_if.sink         csr_ch,
   output tppr_pkg::cfg_type cfg
);

   tppr_pkg::cfg_type cfg_ff;
   tppr_pkg::cfg_type cfg_in;
   logic              write_en;

   // Writes are always taken.
   assign csr_ch.ready = 1'b1;
   assign write_en     = csr_ch.valid;

   // Decode the index and update the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_ch.index)
            tppr_pkg::CSR_START_VOLTAGE: cfg_in.start_voltage_counts = csr_ch.data[9:0];
            tppr_pkg::CSR_TARGET_POWER:  cfg_in.target_power = csr_ch.data[19:0];
            tppr_pkg::CSR_POWER_BAND:    cfg_in.power_band   = csr_ch.data[19:0];
            tppr_pkg::CSR_PITCH_STEP:    cfg_in.pitch_step   = csr_ch.data[5:0];
            tppr_pkg::CSR_NORMAL_PITCH:  cfg_in.normal_pitch = csr_ch.data[7:0];
            tppr_pkg::CSR_CUT_IN_PITCH:  cfg_in.cut_in_pitch = csr_ch.data[7:0];
            tppr_pkg::CSR_MIN_PITCH:     cfg_in.min_pitch    = csr_ch.data[7:0];
            tppr_pkg::CSR_MAX_PITCH:     cfg_in.max_pitch    = csr_ch.data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Register bank with its reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_voltage_counts <= tppr_pkg::RST_START_VOLTAGE;
         cfg_ff.target_power         <= tppr_pkg::RST_TARGET_POWER;
         cfg_ff.power_band           <= tppr_pkg::RST_POWER_BAND;
         cfg_ff.pitch_step           <= tppr_pkg::RST_PITCH_STEP;
         cfg_ff.normal_pitch         <= tppr_pkg::RST_NORMAL_PITCH;
         cfg_ff.cut_in_pitch         <= tppr_pkg::RST_CUT_IN_PITCH;
         cfg_ff.min_pitch            <= tppr_pkg::RST_MIN_PITCH;
         cfg_ff.max_pitch            <= tppr_pkg::RST_MAX_PITCH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> rtl/core/turbine_pitch_power_regulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Turbine pitch and power regulator
// Five-mode turbine controller with perturb-and-observe pitch regulation.
// ----------------------------------------------------------------------------
// Each request word is one control tick: an ADC current sample, the stop
// button level and an optional serial command byte. Each tick produces
// exactly one response word with the pitch command, the relay state, an
// optional event report and the mode after the tick.
// The squared sample is the power; one multiplier and the mode logic sit
// between the request port and the response register, so a response is
// valid in the cycle after its request is accepted. A new request is taken
// every cycle, also while the previous response is being taken.
// When the receiver stalls, the response register holds its word and the
// request side stalls only while that register is full and not taken.
// Configuration writes are taken in any cycle and are meant for idle
// periods. Reset (synchronous) restores the register defaults, puts the
// controller in start-up with the relay open and empties the response
// register.
// ----------------------------------------------------------------------------
module turbine_pitch_power_regulator #(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic clock,
   input  wire logic reset,
   tppr_req_if.sink   req_ch,
   tppr_rsp_if.source rsp_ch,
   tppr_csr_if.sink   csr_ch
);

   localparam int PowerW = 2 * SAMPLE_BITS;
   localparam int CmpW   = ((PowerW > tppr_pkg::ERR_W + 1) ? PowerW : tppr_pkg::ERR_W + 1) + 1;

   tppr_pkg::cfg_type cfg;

   // Controller state.
   tppr_pkg::mode_type          mode_ff, mode_in;
   logic                        observe_ff, observe_in;
   logic [7:0]                  reg_pitch_ff, reg_pitch_in;
   logic                        step_up_ff, step_up_in;
   logic [tppr_pkg::ERR_W-1:0]  saved_err_ff, saved_err_in;
   logic                        relay_ff, relay_in;

   // Response register.
   logic       rsp_valid_ff;
   logic [7:0] pitch_ff, pitch_in;
   logic       report_valid_ff, report_valid_in;
   logic [1:0] report_code_ff, report_code_in;

   logic                       accept;
   logic [SAMPLE_BITS-1:0]     sample;
   logic [PowerW-1:0]          power;
   logic [CmpW-1:0]            power_ext;
   logic [CmpW-1:0]            target_ext;
   logic [CmpW-1:0]            upper_limit;
   logic [CmpW-1:0]            diff;
   logic [tppr_pkg::ERR_W-1:0] err;
   logic                       start_reached;
   logic [8:0]                 down_floor;
   logic [8:0]                 up_sum;
   logic                       down_ok;
   logic                       up_ok;

   tppr_csr_regs u_csr_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Handshake: take a word when the response register is free or drains.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // Power, saturated error and threshold compares.
   assign sample      = req_ch.current_sample;
   assign power       = PowerW'(sample) * PowerW'(sample);
   assign power_ext   = CmpW'(power);
   assign target_ext  = CmpW'(cfg.target_power);
   assign upper_limit = target_ext + CmpW'(cfg.power_band);
   assign diff        = (power_ext > target_ext) ? (power_ext - target_ext)
                                                 : (target_ext - power_ext);
   assign err         = (diff > CmpW'(tppr_pkg::ERR_MAX)) ? tppr_pkg::ERR_MAX
                                                          : diff[tppr_pkg::ERR_W-1:0];
   assign start_reached = CmpW'(sample) >= CmpW'(cfg.start_voltage_counts);

   // Pitch step limits for the perturb tick.
   assign down_floor = {1'b0, cfg.min_pitch} + 9'(cfg.pitch_step);
   assign up_sum     = {1'b0, reg_pitch_ff} + 9'(cfg.pitch_step);
   assign down_ok    = !step_up_ff && ({1'b0, reg_pitch_ff} >= down_floor);
   assign up_ok      = step_up_ff && (up_sum <= {1'b0, cfg.max_pitch});

   // Mode sequencing and result for the current word.
   always_comb begin
      mode_in         = mode_ff;
      observe_in      = observe_ff;
      reg_pitch_in    = reg_pitch_ff;
      step_up_in      = step_up_ff;
      saved_err_in    = saved_err_ff;
      relay_in        = relay_ff;
      pitch_in        = cfg.max_pitch;
      report_valid_in = 1'b0;
      report_code_in  = tppr_pkg::REPORT_ONLINE;
      case (mode_ff)
         tppr_pkg::MODE_START: begin
            pitch_in = cfg.cut_in_pitch;
            relay_in = 1'b1;
            if (start_reached) begin
               relay_in        = 1'b0;
               report_valid_in = 1'b1;
               report_code_in  = tppr_pkg::REPORT_ONLINE;
               mode_in         = tppr_pkg::MODE_NORMAL;
            end
         end
         tppr_pkg::MODE_NORMAL: begin
            pitch_in = cfg.normal_pitch;
            // Stop wins over disconnect, disconnect over regulation.
            if (!req_ch.stop_released) begin
               mode_in         = tppr_pkg::MODE_STOP;
               report_valid_in = 1'b1;
               report_code_in  = tppr_pkg::REPORT_STOP;
               relay_in        = 1'b1;
               pitch_in        = cfg.max_pitch;
            end else if (req_ch.cmd_valid && req_ch.cmd_byte == tppr_pkg::CMD_DISCONNECT) begin
               mode_in  = tppr_pkg::MODE_DISC;
               relay_in = 1'b1;
               pitch_in = cfg.max_pitch;
            end else if (power_ext > upper_limit) begin
               mode_in = tppr_pkg::MODE_REG;
            end
         end
         tppr_pkg::MODE_REG: begin
            if (!observe_ff) begin
               // Perturb tick: above the band, step and remember the error.
               if (err > cfg.power_band) begin
                  if (down_ok) begin
                     reg_pitch_in = reg_pitch_ff - 8'(cfg.pitch_step);
                  end else if (up_ok) begin
                     reg_pitch_in = up_sum[7:0];
                  end
                  saved_err_in = err;
                  observe_in   = 1'b1;
               end else if (reg_pitch_ff == cfg.normal_pitch) begin
                  mode_in = tppr_pkg::MODE_NORMAL;
               end
            end else begin
               // Observe tick: reverse when the error grew.
               if (err > saved_err_ff) begin
                  step_up_in = !step_up_ff;
               end
               observe_in = 1'b0;
               if (reg_pitch_ff == cfg.normal_pitch) begin
                  mode_in = tppr_pkg::MODE_NORMAL;
               end
            end
            pitch_in = reg_pitch_in;
         end
         tppr_pkg::MODE_STOP: begin
            pitch_in = cfg.max_pitch;
            relay_in = 1'b1;
            if (req_ch.stop_released) begin
               report_valid_in = 1'b1;
               report_code_in  = tppr_pkg::REPORT_RELEASE;
               pitch_in        = cfg.cut_in_pitch;
               mode_in         = tppr_pkg::MODE_START;
            end
         end
         default: begin
            mode_in  = tppr_pkg::MODE_DISC;
            pitch_in = cfg.max_pitch;
            relay_in = 1'b1;
         end
      endcase
   end

   // Controller state register, advanced once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= tppr_pkg::MODE_START;
         observe_ff   <= 1'b0;
         reg_pitch_ff <= tppr_pkg::RST_REGULATED_PITCH;
         step_up_ff   <= 1'b1;
         saved_err_ff <= '0;
         relay_ff     <= 1'b1;
      end else if (accept) begin
         mode_ff      <= mode_in;
         observe_ff   <= observe_in;
         reg_pitch_ff <= reg_pitch_in;
         step_up_ff   <= step_up_in;
         saved_err_ff <= saved_err_in;
         relay_ff     <= relay_in;
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload; the relay and mode fields come from the state register.
   always_ff @(posedge clock) begin
      if (accept) begin
         pitch_ff        <= pitch_in;
         report_valid_ff <= report_valid_in;
         report_code_ff  <= report_code_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pitch_command = pitch_ff;
   assign rsp_ch.relay_open    = relay_ff;
   assign rsp_ch.report_valid  = report_valid_ff;
   assign rsp_ch.report_code   = report_code_ff;
   assign rsp_ch.mode_now      = mode_ff;

`ifndef SYNTH
   // The observe phase exists only while regulating.
   a_observe_in_reg : assert property (@(posedge clock) disable iff (reset)
      observe_ff |-> (mode_ff == tppr_pkg::MODE_REG))
      else $error("observe phase set outside regulate mode");

   // Stopped and disconnected modes always report an open relay.
   a_safe_relay : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (mode_ff == tppr_pkg::MODE_STOP || mode_ff == tppr_pkg::MODE_DISC))
      |-> relay_ff)
      else $error("relay closed in stop or disconnect mode");

   // An online report comes with a closed relay and normal mode.
   a_online_report : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && report_valid_ff && report_code_ff == tppr_pkg::REPORT_ONLINE)
      |-> (!relay_ff && mode_ff == tppr_pkg::MODE_NORMAL))
      else $error("online report without closed relay in normal mode");
`endif

endmodule
`default_nettype wire

>>> test/tb_turbine_pitch_power_regulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turbine pitch and power regulator testbench
// Drives control ticks into the regulator and checks every response word
// against an in-bench model of the five-mode controller or a typed script
// result. A short scripted opening covers start-up, stop, release and a
// regulation walk. Random phases follow under several register settings
// and idling patterns, with a long receiver hold-off backing up requests.
// ----------------------------------------------------------------------------
module tb_turbine_pitch_power_regulator;

   localparam int SAMPLE_BITS = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;

   // One control tick as sent on the request channel.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   stop_released;
      logic                   cmd_valid;
      logic [7:0]             cmd_byte;
   } tick_word_type;

   // One response word.
   typedef struct packed {
      logic [7:0]         pitch_command;
      logic               relay_open;
      logic               report_valid;
      logic [1:0]         report_code;
      tppr_pkg::mode_type mode_now;
   } tick_result_type;

   // Opening script row; the result is used only where typed is set.
   typedef struct {
      tick_word_type   word;
      bit              typed;
      tick_result_type result;
   } script_row_type;

   // One random phase: register settings, sample center and idling.
   typedef struct {
      tppr_pkg::cfg_type regs;
      int                knee;
      int                tx_idle;
      int                rx_stall;
      int                count;
      bit                pressure;
      bit                disconnect_ok;
   } phase_type;

   localparam tppr_pkg::cfg_type DEFAULT_REGS = '{tppr_pkg::RST_START_VOLTAGE,
      tppr_pkg::RST_TARGET_POWER, tppr_pkg::RST_POWER_BAND, tppr_pkg::RST_PITCH_STEP,
      tppr_pkg::RST_NORMAL_PITCH, tppr_pkg::RST_CUT_IN_PITCH, tppr_pkg::RST_MIN_PITCH,
      tppr_pkg::RST_MAX_PITCH};

   localparam tick_result_type NO_RESULT = '{8'd0, 1'b0, 1'b0, tppr_pkg::REPORT_ONLINE,
      tppr_pkg::MODE_START};

   logic clock = 1'b0;
   logic reset = 1'b1;

   tppr_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   tppr_rsp_if rsp_ch ();
   tppr_csr_if csr_ch ();

   turbine_pitch_power_regulator #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Model state and register copy.
   tppr_pkg::cfg_type  cfg;
   tppr_pkg::mode_type ctl_mode;
   logic               observing;
   logic [7:0]         reg_pitch;
   logic               step_up;
   logic [19:0]        saved_err;
   logic               relay_st;

   tick_result_type expected_q[$];
   int              mismatch_count = 0;
   int unsigned     cycle_count = 0;
   int              tx_idle_pct = 0;
   int              rx_stall_pct = 0;
   logic            hold_trigger = 1'b0;
   logic            hold_seen = 1'b0;
   int              hold_left = 0;

   // Opening script, run on the reset register values.
   script_row_type opening_script [21] = '{
      '{'{10'd0, 1'b1, 1'b1, tppr_pkg::CMD_DISCONNECT}, 1'b1,
        '{8'd50, 1'b1, 1'b0, tppr_pkg::REPORT_ONLINE, tppr_pkg::MODE_START}},
      '{'{10'd47, 1'b0, 1'b0, 8'h00}, 1'b1,
        '{8'd50, 1'b1, 1'b0, tppr_pkg::REPORT_ONLINE, tppr_pkg::MODE_START}},
      '{'{10'd48, 1'b1, 1'b0, 8'h00}, 1'b1,
        '{8'd50, 1'b0, 1'b1, tppr_pkg::REPORT_ONLINE, tppr_pkg::MODE_NORMAL}},
      '{'{10'd0, 1'b0, 1'b0, 8'h00}, 1'b1,
        '{8'd140, 1'b1, 1'b1, tppr_pkg::REPORT_STOP, tppr_pkg::MODE_STOP}},
      '{'{10'd1023, 1'b0, 1'b1, tppr_pkg::CMD_DISCONNECT}, 1'b1,
        '{8'd140, 1'b1, 1'b0, tppr_pkg::REPORT_ONLINE, tppr_pkg::MODE_STOP}},
      '{'{10'd0, 1'b1, 1'b0, 8'h00}, 1'b1,
        '{8'd50, 1'b1, 1'b1, tppr_pkg::REPORT_RELEASE, tppr_pkg::MODE_START}},
      '{'{10'd1023, 1'b1, 1'b1, 8'hFF}, 1'b1,
        '{8'd50, 1'b0, 1'b1, tppr_pkg::REPORT_ONLINE, tppr_pkg::MODE_NORMAL}},
      '{'{10'd116, 1'b1, 1'b1, 8'hFF}, 1'b0, NO_RESULT},
      '{'{10'd117, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RESULT},
      '{'{10'd1023, 1'b0, 1'b1, tppr_pkg::CMD_DISCONNECT}, 1'b0, NO_RESULT},
      '{'{10'd0, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RESULT},
      '{'{10'd0, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RESULT},
      '{'{10'd1023, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RESULT},
      '{'{10'd115, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RESULT},
      '{'{10'd200, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RESULT},
      '{'{10'd200, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RESULT},
      '{'{10'd200, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RESULT},
      '{'{10'd200, 1'b1, 1'b0, 8'h00}, 1'b0, NO_RESULT},
      '{'{10'd116, 1'b1, 1'b0, tppr_pkg::CMD_DISCONNECT}, 1'b0, NO_RESULT},
      '{'{10'd1023, 1'b1, 1'b0, 8'h80}, 1'b0, NO_RESULT},
      '{'{10'd900, 1'b1, 1'b1, 8'h7F}, 1'b0, NO_RESULT}
   };

   // Random phases: defaults, all-low and all-high extremes, a mid setting,
   // a narrow pitch window under receiver pressure, and a closing phase
   // where the disconnect command may arrive.
   phase_type run_plan [6] = '{
      '{DEFAULT_REGS, 115, 0, 0, 100, 1'b0, 1'b0},
      '{'{10'd0, 20'd0, 20'd0, 6'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        2, 52, 0, 70, 1'b0, 1'b0},
      '{'{10'd30, 20'd40000, 20'd600, 6'd5, 8'd100, 8'd40, 8'd60, 8'd150},
        200, 0, 52, 100, 1'b0, 1'b0},
      '{'{10'h3FF, 20'hFFFFF, 20'hFFFFF, 6'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        1020, 8, 8, 60, 1'b0, 1'b0},
      '{'{10'd10, 20'd10000, 20'd0, 6'd1, 8'd90, 8'd20, 8'd80, 8'd100},
        100, 0, 0, 100, 1'b1, 1'b0},
      '{DEFAULT_REGS, 115, 8, 8, 60, 1'b0, 1'b1}
   };

   // Clock, 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advances the controller model by one tick and returns its response.
   function automatic tick_result_type regulate_tick(input tick_word_type w);
      tick_result_type r;
      int              power;
      int              err;
      bit              leave_ok;
      power = int'(w.sample) * int'(w.sample);
      err = (power > int'(cfg.target_power)) ? power - int'(cfg.target_power)
                                             : int'(cfg.target_power) - power;
      if (err > int'(tppr_pkg::ERR_MAX)) err = int'(tppr_pkg::ERR_MAX);
      r = NO_RESULT;
      case (ctl_mode)
         tppr_pkg::MODE_START: begin
            r.pitch_command = cfg.cut_in_pitch;
            relay_st = 1'b1;
            if (w.sample >= cfg.start_voltage_counts) begin
               relay_st = 1'b0;
               r.report_valid = 1'b1;
               r.report_code = tppr_pkg::REPORT_ONLINE;
               ctl_mode = tppr_pkg::MODE_NORMAL;
            end
         end
         tppr_pkg::MODE_NORMAL: begin
            r.pitch_command = cfg.normal_pitch;
            if (!w.stop_released) begin
               ctl_mode = tppr_pkg::MODE_STOP;
               r.report_valid = 1'b1;
               r.report_code = tppr_pkg::REPORT_STOP;
               relay_st = 1'b1;
               r.pitch_command = cfg.max_pitch;
            end else if (w.cmd_valid && w.cmd_byte == tppr_pkg::CMD_DISCONNECT) begin
               ctl_mode = tppr_pkg::MODE_DISC;
               relay_st = 1'b1;
               r.pitch_command = cfg.max_pitch;
            end else if (power > int'(cfg.target_power) + int'(cfg.power_band)) begin
               ctl_mode = tppr_pkg::MODE_REG;
            end
         end
         tppr_pkg::MODE_REG: begin
            // Perturb on one tick, observe the error on the next.
            leave_ok = 1'b1;
            if (!observing) begin
               if (err > int'(cfg.power_band)) begin
                  if (!step_up) begin
                     if (int'(reg_pitch) >= int'(cfg.min_pitch) + int'(cfg.pitch_step))
                        reg_pitch = reg_pitch - cfg.pitch_step;
                  end else if (int'(reg_pitch) + int'(cfg.pitch_step)
                               <= int'(cfg.max_pitch)) begin
                     reg_pitch = reg_pitch + cfg.pitch_step;
                  end
                  saved_err = err[19:0];
                  observing = 1'b1;
                  leave_ok = 1'b0;
               end
            end else begin
               if (err > int'(saved_err)) step_up = !step_up;
               observing = 1'b0;
            end
            if (leave_ok && reg_pitch == cfg.normal_pitch) ctl_mode = tppr_pkg::MODE_NORMAL;
            r.pitch_command = reg_pitch;
         end
         tppr_pkg::MODE_STOP: begin
            r.pitch_command = cfg.max_pitch;
            relay_st = 1'b1;
            if (w.stop_released) begin
               r.report_valid = 1'b1;
               r.report_code = tppr_pkg::REPORT_RELEASE;
               r.pitch_command = cfg.cut_in_pitch;
               ctl_mode = tppr_pkg::MODE_START;
            end
         end
         default: begin
            ctl_mode = tppr_pkg::MODE_DISC;
            r.pitch_command = cfg.max_pitch;
            relay_st = 1'b1;
         end
      endcase
      r.relay_open = relay_st;
      r.mode_now = ctl_mode;
      return r;
   endfunction

   // Draws a tick, mostly with samples around the regulation knee.
   function automatic tick_word_type random_tick(input int knee, input bit disconnect_ok);
      tick_word_type w;
      int            s;
      case ($urandom_range(9))
         0, 1: s = $urandom_range(1023);
         2: s = $urandom_range(1) ? 1023 : 0;
         default: s = knee + int'($urandom_range(12)) - 6;
      endcase
      if (s < 0) s = 0;
      else if (s > 1023) s = 1023;
      w.sample = s[SAMPLE_BITS-1:0];
      w.stop_released = ($urandom_range(19) != 0);
      w.cmd_valid = 1'($urandom_range(1));
      w.cmd_byte = 8'($urandom_range(255));
      // The disconnect is final, so it is kept for the closing phase.
      if (w.cmd_valid && w.cmd_byte == tppr_pkg::CMD_DISCONNECT && !disconnect_ok)
         w.cmd_byte = ~tppr_pkg::CMD_DISCONNECT;
      if (disconnect_ok && $urandom_range(39) == 0) begin
         w.cmd_valid = 1'b1;
         w.cmd_byte = tppr_pkg::CMD_DISCONNECT;
      end
      return w;
   endfunction

   // Sends one request word, then records what it should produce.
   task automatic send_tick(input tick_word_type w, input bit typed,
                            input tick_result_type result);
      tick_result_type predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.current_sample <= w.sample;
      req_ch.stop_released <= w.stop_released;
      req_ch.cmd_valid <= w.cmd_valid;
      req_ch.cmd_byte <= w.cmd_byte;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = regulate_tick(w);
      expected_q.push_back(typed ? result : predicted);
   endtask

   // Writes one register; the caller lowers valid after the last write.
   task automatic write_reg(input logic [tppr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [tppr_pkg::CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (idx)
         tppr_pkg::CSR_START_VOLTAGE: cfg.start_voltage_counts = value[9:0];
         tppr_pkg::CSR_TARGET_POWER:  cfg.target_power = value;
         tppr_pkg::CSR_POWER_BAND:    cfg.power_band = value;
         tppr_pkg::CSR_PITCH_STEP:    cfg.pitch_step = value[5:0];
         tppr_pkg::CSR_NORMAL_PITCH:  cfg.normal_pitch = value[7:0];
         tppr_pkg::CSR_CUT_IN_PITCH:  cfg.cut_in_pitch = value[7:0];
         tppr_pkg::CSR_MIN_PITCH:     cfg.min_pitch = value[7:0];
         default:                     cfg.max_pitch = value[7:0];
      endcase
   endtask

   task automatic program_regs(input tppr_pkg::cfg_type regs);
      write_reg(tppr_pkg::CSR_START_VOLTAGE, {10'd0, regs.start_voltage_counts});
      write_reg(tppr_pkg::CSR_TARGET_POWER, regs.target_power);
      write_reg(tppr_pkg::CSR_POWER_BAND, regs.power_band);
      write_reg(tppr_pkg::CSR_PITCH_STEP, {14'd0, regs.pitch_step});
      write_reg(tppr_pkg::CSR_NORMAL_PITCH, {12'd0, regs.normal_pitch});
      write_reg(tppr_pkg::CSR_CUT_IN_PITCH, {12'd0, regs.cut_in_pitch});
      write_reg(tppr_pkg::CSR_MIN_PITCH, {12'd0, regs.min_pitch});
      write_reg(tppr_pkg::CSR_MAX_PITCH, {12'd0, regs.max_pitch});
      csr_ch.valid <= 1'b0;
   endtask

   // Stops sending and waits until every expected word has arrived.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   task automatic report_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Response check against the oldest expected word.
   always @(posedge clock) begin : response_check
      tick_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_q.size() == 0) begin
            $display("%0t ns: unexpected response word, pitch %0d mode %0d",
                     $time, rsp_ch.pitch_command, rsp_ch.mode_now);
            mismatch_count++;
         end else begin
            want = expected_q.pop_front();
            report_field("pitch_command", want.pitch_command, rsp_ch.pitch_command);
            report_field("relay_open", 8'(want.relay_open), 8'(rsp_ch.relay_open));
            report_field("report_valid", 8'(want.report_valid), 8'(rsp_ch.report_valid));
            report_field("report_code", 8'(want.report_code), 8'(rsp_ch.report_code));
            report_field("mode_now", 8'(want.mode_now), 8'(rsp_ch.mode_now));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_turbine_pitch_power_regulator failed");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      req_ch.valid = 1'b0;
      req_ch.current_sample = '0;
      req_ch.stop_released = 1'b1;
      req_ch.cmd_valid = 1'b0;
      req_ch.cmd_byte = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = tppr_pkg::CSR_START_VOLTAGE;
      csr_ch.data = '0;
      rsp_ch.ready = 1'b0;
      cfg = DEFAULT_REGS;
      ctl_mode = tppr_pkg::MODE_START;
      observing = 1'b0;
      reg_pitch = tppr_pkg::RST_REGULATED_PITCH;
      step_up = 1'b1;
      saved_err = '0;
      relay_st = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Scripted opening on the reset register values.
      foreach (opening_script[i])
         send_tick(opening_script[i].word, opening_script[i].typed, opening_script[i].result);
      settle();

      // Random phases, registers rewritten while the block is idle.
      foreach (run_plan[p]) begin
         program_regs(run_plan[p].regs);
         tx_idle_pct = run_plan[p].tx_idle;
         rx_stall_pct <= run_plan[p].rx_stall;
         if (run_plan[p].pressure) hold_trigger <= ~hold_trigger;
         for (int n = 0; n < run_plan[p].count; n++)
            send_tick(random_tick(run_plan[p].knee, run_plan[p].disconnect_ok), 1'b0,
                      NO_RESULT);
         settle();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("tb_turbine_pitch_power_regulator passed");
      else
         $display("tb_turbine_pitch_power_regulator failed");
      $finish;
   end

endmodule
